// File: sv/mikmc_pkg.sv
// Package: constants, codes and transaction types of the MRU id/key map cache.
`timescale 1ns / 1ps

package mikmc_pkg;

  // Storage geometry
  localparam int CAPACITY  = 128;
  localparam int KEY_WORDS = 4;
  localparam int WORD_W    = 64;
  localparam int ID_W      = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // Configuration registers
  localparam int LIMIT_W    = 8;
  localparam int TURNOVER_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURNOVER    = 2'd1;
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 8'd100;
  localparam logic [TURNOVER_W-1:0] TURNOVER_RESET = 7'd10;

  // Action codes
  localparam logic [1:0] ACT_LOOKUP_ID  = 2'd0;
  localparam logic [1:0] ACT_LOOKUP_KEY = 2'd1;
  localparam logic [1:0] ACT_STORE      = 2'd2;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // One stored entry
  typedef struct packed {
    logic [ID_W-1:0] id;
    key_t            key;
  } entry_t;

  // Input transaction
  typedef struct packed {
    logic [1:0]        action;
    logic [ID_W-1:0]   id_in;
    logic [WORD_W-1:0] key_w0;
    logic [WORD_W-1:0] key_w1;
    logic [WORD_W-1:0] key_w2;
    logic [WORD_W-1:0] key_w3;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic              hit;
    logic [ID_W-1:0]   id_out;
    logic [WORD_W-1:0] found_w0;
    logic [WORD_W-1:0] found_w1;
    logic [WORD_W-1:0] found_w2;
    logic [WORD_W-1:0] found_w3;
  } out_item_t;

endpackage

// File: sv/mikmc_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module mikmc_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 288
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/mru_id_key_map_cache.sv
// Top level: MRU two-way id/key map cache with sequenced search and shift.
//
// Usage: a transaction on the input channel (in_valid / in_stall / in_data)
// carries an action: lookup by id, lookup by key, or store of an id/key pair.
// Every accepted transaction yields exactly one result on the output channel
// (out_valid / out_stall / out_data). Entries live in a RAM in most-recent-
// first order; one comparator walks them from the front, reading and then
// comparing one entry at a time, and a hit or a store moves entries back one
// slot at a time through the single RAM read/write port pair, each move a
// read and then a write.
// One transaction is in flight at a time; in_stall is high while it works.
// The result waits in an output register; if the receiver stalls, the next
// transaction still runs but holds in its final state, with in_stall high,
// until that register frees up.
// Reset (rst_n low, synchronous) empties the map and restores entry_limit to
// 100 and turnover to 10. Write the cfg_ port only while no transaction is
// in flight.
`timescale 1ns / 1ps

module mru_id_key_map_cache (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mikmc_pkg::in_item_t                 in_data,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output mikmc_pkg::out_item_t                out_data,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [mikmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mikmc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int ADDR_W = mikmc_pkg::ADDR_W;
  localparam int CNT_W  = mikmc_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FRONT,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [CNT_W-1:0]                 idx_r, idx_nxt;
  logic [mikmc_pkg::LIMIT_W-1:0]    limit_r, limit_nxt;
  logic [mikmc_pkg::TURNOVER_W-1:0] turnover_r, turnover_nxt;
  logic                             hit_r, hit_nxt;
  logic [1:0]                       action_r, action_nxt;
  mikmc_pkg::entry_t                pair_r, pair_nxt;
  logic                             out_valid_r, out_valid_nxt;
  mikmc_pkg::out_item_t             out_data_r, out_data_nxt;

  // RAM port signals
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ADDR_W-1:0]      ram_raddr;
  mikmc_pkg::entry_t      ram_wdata;
  mikmc_pkg::entry_t      ram_rdata;

  logic [CNT_W-1:0]       idx_dec;
  logic [CNT_W-1:0]       idx_inc;
  logic [CNT_W-1:0]       trim_cnt;
  logic [CNT_W-1:0]       ins_pos;
  logic                   match;
  mikmc_pkg::entry_t      in_entry;

  mikmc_ram #(
    .DEPTH (mikmc_pkg::CAPACITY),
    .WIDTH ($bits(mikmc_pkg::entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_dec = idx_r - CNT_W'(1);
  assign idx_inc = idx_r + CNT_W'(1);

  // Incoming pair as an entry
  always_comb begin
    in_entry.id     = in_data.id_in;
    in_entry.key[0] = in_data.key_w0;
    in_entry.key[1] = in_data.key_w1;
    in_entry.key[2] = in_data.key_w2;
    in_entry.key[3] = in_data.key_w3;
  end

  // Trim on store, then clamp so the new entry fits
  always_comb begin
    trim_cnt = count_r;
    if ((count_r >= limit_r) && (count_r > CNT_W'(turnover_r))) begin
      trim_cnt = count_r - CNT_W'(turnover_r);
    end
    ins_pos = trim_cnt;
    if (trim_cnt >= CNT_W'(mikmc_pkg::CAPACITY)) begin
      ins_pos = CNT_W'(mikmc_pkg::CAPACITY - 1);
    end
  end

  // Shared comparator: id or full key against the entry just read
  assign match = (action_r == mikmc_pkg::ACT_LOOKUP_ID) ? (ram_rdata.id == pair_r.id)
                                                        : (ram_rdata.key == pair_r.key);

  // RAM addressing
  always_comb begin
    ram_raddr = idx_r[ADDR_W-1:0];
    if (state_r == S_SHIFT_RD) begin
      ram_raddr = idx_dec[ADDR_W-1:0];
    end
    ram_we    = 1'b0;
    ram_waddr = idx_r[ADDR_W-1:0];
    ram_wdata = ram_rdata;
    if (state_r == S_SHIFT_WR) begin
      ram_we = 1'b1;
    end else if (state_r == S_FRONT) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = pair_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    limit_nxt     = limit_r;
    turnover_nxt  = turnover_r;
    hit_nxt       = hit_r;
    action_nxt    = action_r;
    pair_nxt      = pair_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        mikmc_pkg::REG_ENTRY_LIMIT: limit_nxt = cfg_wdata;
        mikmc_pkg::REG_TURNOVER:    turnover_nxt = cfg_wdata[mikmc_pkg::TURNOVER_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          action_nxt = in_data.action;
          pair_nxt   = in_entry;
          hit_nxt    = 1'b0;
          idx_nxt    = '0;
          if ((in_data.action == mikmc_pkg::ACT_LOOKUP_ID) ||
              (in_data.action == mikmc_pkg::ACT_LOOKUP_KEY)) begin
            state_nxt = (count_r == '0) ? S_RESP : S_SCAN_RD;
          end else if (in_data.action == mikmc_pkg::ACT_STORE) begin
            count_nxt = ins_pos + CNT_W'(1);
            idx_nxt   = ins_pos;
            state_nxt = (ins_pos == '0) ? S_FRONT : S_SHIFT_RD;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (match) begin
          hit_nxt   = 1'b1;
          pair_nxt  = ram_rdata;
          state_nxt = (idx_r == '0) ? S_FRONT : S_SHIFT_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc == count_r) ? S_RESP : S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        idx_nxt   = idx_dec;
        state_nxt = (idx_dec == '0) ? S_FRONT : S_SHIFT_RD;
      end
      S_FRONT: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (hit_r) begin
            out_data_nxt.hit      = 1'b1;
            out_data_nxt.id_out   = pair_r.id;
            out_data_nxt.found_w0 = pair_r.key[0];
            out_data_nxt.found_w1 = pair_r.key[1];
            out_data_nxt.found_w2 = pair_r.key[2];
            out_data_nxt.found_w3 = pair_r.key[3];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      limit_r     <= mikmc_pkg::LIMIT_RESET;
      turnover_r  <= mikmc_pkg::TURNOVER_RESET;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      limit_r     <= limit_nxt;
      turnover_r  <= turnover_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    action_r   <= action_nxt;
    pair_r     <= pair_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
